### rtl/postfix_expression_evaluator_core_assert.svh
// assertion macros for the postfix evaluator core
// used by the top level only, needs clk_i and rst_ni in scope
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PFX_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define PFX_ASSERT_NR(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");
`else
`define PFX_ASSERT(label, prop)
`define PFX_ASSERT_NR(label, prop)
`endif

`endif

### rtl/pfx_pkg.sv
// shared types and constants for the postfix evaluator core
// no dependencies
package pfx_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned SymW       = 8;
  localparam int unsigned DepthW     = 5;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned StackDepth = 16;

  localparam logic [SymW-1:0] SymZero  = 8'h30;
  localparam logic [SymW-1:0] SymNine  = 8'h39;
  localparam logic [SymW-1:0] SymPlus  = 8'h2B;
  localparam logic [SymW-1:0] SymMinus = 8'h2D;
  localparam logic [SymW-1:0] SymMul   = 8'h2A;
  localparam logic [SymW-1:0] SymDiv   = 8'h2F;
  localparam logic [SymW-1:0] SymMod   = 8'h25;

  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StUnder   = 3'd1;
  localparam logic [StatusW-1:0] StOver    = 3'd2;
  localparam logic [StatusW-1:0] StDivZero = 3'd3;
  localparam logic [StatusW-1:0] StUnknown = 3'd4;

  typedef struct packed {
    logic push;
    logic pop;
  } pfx_shift_t;

endpackage

### rtl/pfx_cell.sv
// one stack cell of the shifting operand stack
// depends on pfx_pkg
module pfx_cell (
  input  logic                           clk_i,
  input  pfx_pkg::pfx_shift_t            ctrl_i,
  input  logic [pfx_pkg::DataW-1:0]      above_i,
  input  logic [pfx_pkg::DataW-1:0]      below_i,
  output logic [pfx_pkg::DataW-1:0]      value_o
);
  import pfx_pkg::*;

  logic [DataW-1:0] value_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      value_q <= above_i;
    end else if (ctrl_i.pop) begin
      value_q <= below_i;
    end
  end

  assign value_o = value_q;

endmodule

### rtl/pfx_div.sv
// iterative radix-2 signed divider, one quotient bit per cycle
// truncating quotient, remainder takes the dividend's sign; depends on pfx_pkg
module pfx_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pfx_pkg::DataW-1:0] dividend_i,
  input  logic [pfx_pkg::DataW-1:0] divisor_i,
  output logic [pfx_pkg::DataW-1:0] quotient_o,
  output logic [pfx_pkg::DataW-1:0] remainder_o,
  output logic                      done_o
);
  import pfx_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic [DataW-1:0] rem_q, quo_q, mag_b_q;
  logic             neg_q_q, neg_r_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DataW-1:0] mag_a, mag_b;
  logic [DataW:0]   trial;

  assign mag_a = dividend_i[DataW-1] ? (DataW'(0) - dividend_i) : dividend_i;
  assign mag_b = divisor_i[DataW-1] ? (DataW'(0) - divisor_i) : divisor_i;
  assign trial = {rem_q, quo_q[DataW-1]} - {1'b0, mag_b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= '0;
      quo_q   <= mag_a;
      mag_b_q <= mag_b;
      neg_q_q <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
      neg_r_q <= dividend_i[DataW-1];
    end else if (busy_q) begin
      if (!trial[DataW]) begin
        rem_q <= trial[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DataW-2:0], quo_q[DataW-1]};
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

  assign quotient_o  = neg_q_q ? (DataW'(0) - quo_q) : quo_q;
  assign remainder_o = neg_r_q ? (DataW'(0) - rem_q) : rem_q;
  assign done_o      = done_q;

endmodule

### rtl/postfix_expression_evaluator_core.sv
// postfix evaluator top level: sequencer, operand stack as a row of shifting cells
// each symbol goes S_EXEC, then S_DIV for / and %, then S_DONE, which commits it
// no new symbol is taken until the result is committed; a stalled output holds it
// asynchronous active-low reset empties the stack and drops any pending result
// depends on pfx_pkg, pfx_cell, pfx_div and the assertion macro header
`include "postfix_expression_evaluator_core_assert.svh"
module postfix_expression_evaluator_core #(
  parameter int unsigned STACK_DEPTH = pfx_pkg::StackDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pfx_pkg::SymW-1:0]      symbol_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [pfx_pkg::DataW-1:0] top_value_o,
  output logic [pfx_pkg::DepthW-1:0]    depth_o,
  output logic [pfx_pkg::StatusW-1:0]   status_o,
  output logic                          final_res_o
);
  import pfx_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [1:0]         act_q, act_d;
  logic [SymW-1:0]    sym_q;
  logic               last_q;
  logic [DataW-1:0]   res_q, res_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [CntW-1:0]    count_q, count_d, count_after;
  logic               out_valid_q;
  logic [DataW-1:0]   top_q;
  logic [DepthW-1:0]  depth_q;
  logic [StatusW-1:0] out_status_q;
  logic               final_q;

  logic               in_xfer, out_free, commit;
  logic               is_digit, is_op, is_divop;
  logic               div_start, div_done;
  logic [DataW-1:0]   div_quo, div_rem;
  logic [DataW-1:0]   top_after;
  pfx_shift_t         shift;
  logic [DataW-1:0]   cell_val [STACK_DEPTH];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == S_DONE) && out_free;

  assign is_digit = (sym_q >= SymZero) && (sym_q <= SymNine);
  assign is_divop = (sym_q == SymDiv) || (sym_q == SymMod);
  assign is_op    = is_divop || (sym_q == SymPlus) || (sym_q == SymMinus) ||
                    (sym_q == SymMul);

  // operand stack, top of stack in cell 0
  assign shift.push = commit && (act_q == ACT_PUSH);
  assign shift.pop  = commit && (act_q == ACT_POP);

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DataW-1:0] above, below;
    if (i == 0) begin : g_head
      assign above = res_q;
      assign below = res_q;
    end else if (i == STACK_DEPTH - 1) begin : g_tail
      assign above = cell_val[i-1];
      assign below = '0;
    end else begin : g_mid
      assign above = cell_val[i-1];
      assign below = cell_val[i+1];
    end
    pfx_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (shift),
      .above_i (above),
      .below_i (below),
      .value_o (cell_val[i])
    );
  end

  pfx_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (cell_val[1]),
    .divisor_i   (cell_val[0]),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    res_d     = res_q;
    status_d  = status_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = StOk;
        act_d    = ACT_NONE;
        state_d  = S_DONE;
        if (is_digit) begin
          if (count_q == CntW'(STACK_DEPTH)) begin
            status_d = StOver;
          end else begin
            act_d = ACT_PUSH;
            res_d = DataW'(sym_q - SymZero);
          end
        end else if (is_op) begin
          if (count_q < CntW'(2)) begin
            status_d = StUnder;
          end else if (is_divop && (cell_val[0] == '0)) begin
            status_d = StDivZero;
          end else begin
            act_d = ACT_POP;
            if (is_divop) begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end else if (sym_q == SymPlus) begin
              res_d = cell_val[1] + cell_val[0];
            end else if (sym_q == SymMinus) begin
              res_d = cell_val[1] - cell_val[0];
            end else begin
              res_d = cell_val[1] * cell_val[0];
            end
          end
        end else begin
          status_d = StUnknown;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = (sym_q == SymDiv) ? div_quo : div_rem;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    case (act_q)
      ACT_PUSH: begin
        count_after = count_q + 1'b1;
        top_after   = res_q;
      end
      ACT_POP: begin
        count_after = count_q - 1'b1;
        top_after   = res_q;
      end
      default: begin
        count_after = count_q;
        top_after   = (count_q != '0) ? cell_val[0] : '0;
      end
    endcase
    count_d = count_q;
    if (commit) begin
      count_d = last_q ? '0 : count_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    res_q    <= res_d;
    status_q <= status_d;
    if (in_xfer) begin
      sym_q  <= symbol_i;
      last_q <= last_i;
    end
    if (commit) begin
      top_q        <= top_after;
      depth_q      <= DepthW'(count_after);
      out_status_q <= status_q;
      final_q      <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = top_q;
  assign depth_o     = depth_q;
  assign status_o    = out_status_q;
  assign final_res_o = final_q;

  `PFX_ASSERT(a_count_bound, count_q <= CntW'(STACK_DEPTH))
  `PFX_ASSERT(a_div_done_state, div_done |-> (state_q == S_DIV))
  `PFX_ASSERT(a_over_full, out_valid_o && (status_o == StOver) |-> depth_o == DepthW'(STACK_DEPTH))
  `PFX_ASSERT_NR(a_reset_quiet, !rst_ni |=> (!out_valid_o && (count_q == '0)))

endmodule
